>>> hw/rtl/sat_pkg.sv
// Shared constants and types of the RGB summed-area table block.
package sat_pkg;

   // Field widths of the channels.
   localparam int PIXEL_W = 8;
   localparam int CFG_W = 10;
   localparam int CSR_IDX_W = 2;
   localparam int SUM_W = 26;
   localparam int NUM_CH = 3;

   // Value limits.
   localparam int PIXEL_MAX = 255;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // Size handling: last-index fields hold up to 4095.
   localparam int SIZE_LAST_W = 12;
   localparam int RESET_SIZE = 512;
   localparam int DEFAULT_MAX_WIDTH = 512;
   localparam int DEFAULT_MAX_HEIGHT = 512;

   // Channel order inside a packed RGB word.
   localparam int CH_RED = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE = 2;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1
   } sat_reg_type;

   // Last column and last row in use, as set by the size registers.
   typedef struct packed {
      logic [SIZE_LAST_W-1:0] col_last;
      logic [SIZE_LAST_W-1:0] row_last;
   } sat_size_type;

   // One summed-area word for all three channels.
   typedef logic [NUM_CH-1:0][SUM_W-1:0] sat_rgb_sum_type;

endpackage

>>> hw/rtl/sat_if.sv
// Handshake channel interfaces of the RGB summed-area table block.

// Pixel input channel.
interface sat_req_if;
   logic                         valid;
   logic                         ready;
   logic [sat_pkg::PIXEL_W-1:0]  pixel_red;
   logic [sat_pkg::PIXEL_W-1:0]  pixel_green;
   logic [sat_pkg::PIXEL_W-1:0]  pixel_blue;

   modport source(output valid, output pixel_red, output pixel_green, output pixel_blue,
                  input ready);
   modport sink(input valid, input pixel_red, input pixel_green, input pixel_blue,
                output ready);
endinterface

// Summed-area result channel.
interface sat_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sat_pkg::SUM_W-1:0]    area_sum_red;
   logic [sat_pkg::SUM_W-1:0]    area_sum_green;
   logic [sat_pkg::SUM_W-1:0]    area_sum_blue;
   logic                         frame_end;

   modport source(output valid, output area_sum_red, output area_sum_green,
                  output area_sum_blue, output frame_end, input ready);
   modport sink(input valid, input area_sum_red, input area_sum_green,
                input area_sum_blue, input frame_end, output ready);
endinterface

// Configuration write channel.
interface sat_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sat_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [sat_pkg::CFG_W-1:0]      write_data;

   modport source(output valid, output reg_index, output write_data, input ready);
   modport sink(input valid, input reg_index, input write_data, output ready);
endinterface

>>> hw/rtl/summed_area_table_rgb.sv
// Top level of the streaming RGB summed-area table.
//
// Pixels enter on req_ch in raster order, one word per handshake. For each
// pixel one word leaves on rsp_ch: the sum of every channel over the rectangle
// from the frame origin to that pixel, plus frame_end on the last pixel of a frame.
// Image width and height are written on csr_ch (index 0 and 1); the user must write
// them only while the block is idle; the block itself does not enforce it. A value
// of zero acts as one and a value above the maximum is clipped. A result word
// passes the input stage and the output register: the accepting edge starts the
// line store read and latches the row sum, and the edge on which the input stage
// advances loads the added and saturated word into the output register. One pixel
// is accepted every cycle while rsp_ch takes its words; the rate is set by the line
// store, which does one read and one write per cycle. A pixel that reads the column
// written in the same cycle takes the written word through a bypass. When rsp_ch
// stalls, the output register holds its word and one more pixel is taken into the
// input stage; after that req_ch.ready drops until the output drains. Reset empties
// both stages, returns the counters to the frame origin and sets both sizes to 512.
// The line store is not cleared: the first row of every frame discards its reads.
module summed_area_table_rgb #(
   parameter int MAX_WIDTH = sat_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sat_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   sat_req_if.sink    req_ch,
   sat_rsp_if.source  rsp_ch,
   sat_csr_if.sink    csr_ch
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int ROW_SUM_W = $clog2(MAX_WIDTH * sat_pkg::PIXEL_MAX + 1);
   localparam int NUM_CH = sat_pkg::NUM_CH;
   localparam int SUM_W = sat_pkg::SUM_W;

   // Add with saturation at the top of the output range.
   function automatic logic [SUM_W-1:0] sat_add(
      input logic [SUM_W-1:0] a,
      input logic [SUM_W-1:0] b
   );
      logic [SUM_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[SUM_W] ? sat_pkg::SUM_MAX : total[SUM_W-1:0];
   endfunction

   sat_pkg::sat_size_type            size;
   logic [COL_W-1:0]                 col_last;
   logic [ROW_W-1:0]                 row_last;

   logic                             req_fire;
   logic                             last_col;
   logic                             last_row;
   logic                             first_row;
   logic                             byp_hit;
   logic                             s1_adv;
   logic [NUM_CH-1:0][sat_pkg::PIXEL_W-1:0] pix;

   logic [COL_W-1:0]                 col_ff, col_in;
   logic [ROW_W-1:0]                 row_ff, row_in;
   logic [NUM_CH-1:0][ROW_SUM_W-1:0] rsum_ff, rsum_in;

   logic                             s1_v_ff, s1_v_in;
   logic [COL_W-1:0]                 s1_col_ff;
   logic                             s1_first_ff;
   logic                             s1_end_ff;
   logic                             s1_byp_ff;
   sat_pkg::sat_rgb_sum_type         s1_byp_data_ff;
   logic [NUM_CH-1:0][ROW_SUM_W-1:0] s1_rsum_ff;

   logic                             out_v_ff, out_v_in;
   sat_pkg::sat_rgb_sum_type         out_sum_ff;
   logic                             out_end_ff;

   sat_pkg::sat_rgb_sum_type         rd_data;
   sat_pkg::sat_rgb_sum_type         above;
   sat_pkg::sat_rgb_sum_type         tbl_val;

   // Size registers.
   sat_csr #(
      .MAX_WIDTH(MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_ch(csr_ch),
      .size_o(size)
   );

   assign col_last = size.col_last[COL_W-1:0];
   assign row_last = size.row_last[ROW_W-1:0];

   // Previous row store.
   sat_line_store #(
      .DEPTH(MAX_WIDTH),
      .ADDR_W(COL_W)
   ) u_line_store (
      .clock(clock),
      .rd_en(req_fire),
      .rd_addr(col_ff),
      .rd_data(rd_data),
      .wr_en(s1_adv),
      .wr_addr(s1_col_ff),
      .wr_data(tbl_val)
   );

   // Handshake and position decode.
   assign s1_adv = s1_v_ff & (~out_v_ff | rsp_ch.ready);
   assign req_ch.ready = ~s1_v_ff | s1_adv;
   assign req_fire = req_ch.valid & req_ch.ready;
   assign last_col = (col_ff >= col_last);
   assign last_row = (row_ff >= row_last);
   assign first_row = (row_ff == '0);
   assign byp_hit = s1_adv & (s1_col_ff == col_ff);

   assign pix[sat_pkg::CH_RED] = req_ch.pixel_red;
   assign pix[sat_pkg::CH_GREEN] = req_ch.pixel_green;
   assign pix[sat_pkg::CH_BLUE] = req_ch.pixel_blue;

   // Counters and running row sums.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      rsum_in = rsum_ff;
      if (req_fire) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
         for (int ch = 0; ch < NUM_CH; ch++) begin
            rsum_in[ch] = ((col_ff == '0) ? '0 : rsum_ff[ch]) + ROW_SUM_W'(pix[ch]);
         end
      end
   end

   // Table value: row sum plus the word above, taken from the bypass if needed.
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (s1_first_ff) begin
            above[ch] = '0;
         end else if (s1_byp_ff) begin
            above[ch] = s1_byp_data_ff[ch];
         end else begin
            above[ch] = rd_data[ch];
         end
         tbl_val[ch] = sat_add(above[ch], SUM_W'(s1_rsum_ff[ch]));
      end
   end

   // Stage valid flags.
   always_comb begin
      s1_v_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_ff);
      out_v_in = s1_adv ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_v_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         rsum_ff <= '0;
         s1_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         rsum_ff <= rsum_in;
         s1_v_ff <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // Input stage and output register payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_col_ff <= col_ff;
         s1_first_ff <= first_row;
         s1_end_ff <= last_col & last_row;
         s1_byp_ff <= byp_hit;
         s1_byp_data_ff <= tbl_val;
         s1_rsum_ff <= rsum_in;
      end
      if (s1_adv) begin
         out_sum_ff <= tbl_val;
         out_end_ff <= s1_end_ff;
      end
   end

   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.area_sum_red = out_sum_ff[sat_pkg::CH_RED];
   assign rsp_ch.area_sum_green = out_sum_ff[sat_pkg::CH_GREEN];
   assign rsp_ch.area_sum_blue = out_sum_ff[sat_pkg::CH_BLUE];
   assign rsp_ch.frame_end = out_end_ff;

   // The last pixel of a frame returns the counters to the origin.
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      req_fire && last_col && last_row |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap after the last pixel of a frame");

   // A bypassed pixel sits at the same column as the word it took.
   a_bypass_col: assert property (@(posedge clock) disable iff (reset)
      req_fire && byp_hit |=> s1_byp_ff && s1_col_ff == $past(s1_col_ff))
      else $error("bypass taken for a different column");

   // A row sum restarts with the pixel at column zero.
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      req_fire && col_ff == '0 |=>
         s1_rsum_ff[sat_pkg::CH_RED] == ROW_SUM_W'($past(req_ch.pixel_red)))
      else $error("row sum did not restart at column zero");

endmodule

>>> hw/rtl/sat_csr.sv
// Image size registers, kept as last column and last row indexes.
module sat_csr #(
   parameter int MAX_WIDTH = sat_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sat_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   sat_csr_if.sink               csr_ch,
   output sat_pkg::sat_size_type size_o
);

   localparam int EXT_W = sat_pkg::SIZE_LAST_W + 1;

   // A size of zero acts as one, a size above the maximum acts as the maximum.
   function automatic logic [sat_pkg::SIZE_LAST_W-1:0] size_last(
      input logic [sat_pkg::CFG_W-1:0] v,
      input logic [EXT_W-1:0]          top
   );
      logic [EXT_W-1:0] v_ext;
      logic [EXT_W-1:0] res;
      v_ext = {{(EXT_W - sat_pkg::CFG_W){1'b0}}, v};
      if (v_ext == '0) begin
         res = '0;
      end else if (v_ext > top) begin
         res = top - EXT_W'(1);
      end else begin
         res = v_ext - EXT_W'(1);
      end
      return res[sat_pkg::SIZE_LAST_W-1:0];
   endfunction

   localparam logic [EXT_W-1:0] TOP_W = EXT_W'(MAX_WIDTH);
   localparam logic [EXT_W-1:0] TOP_H = EXT_W'(MAX_HEIGHT);

   sat_pkg::sat_size_type size_ff;
   sat_pkg::sat_size_type size_in;
   logic                  csr_fire;

   assign csr_ch.ready = 1'b1;
   assign csr_fire = csr_ch.valid & csr_ch.ready;

   // Register decode; unknown indexes are ignored.
   always_comb begin
      size_in = size_ff;
      if (csr_fire) begin
         unique case (csr_ch.reg_index)
            sat_pkg::REG_IMAGE_WIDTH: begin
               size_in.col_last = size_last(csr_ch.write_data, TOP_W);
            end
            sat_pkg::REG_IMAGE_HEIGHT: begin
               size_in.row_last = size_last(csr_ch.write_data, TOP_H);
            end
            default: begin
               size_in = size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff.col_last <= size_last(sat_pkg::CFG_W'(sat_pkg::RESET_SIZE), TOP_W);
         size_ff.row_last <= size_last(sat_pkg::CFG_W'(sat_pkg::RESET_SIZE), TOP_H);
      end else begin
         size_ff <= size_in;
      end
   end

   assign size_o = size_ff;

endmodule

>>> hw/rtl/sat_line_store.sv
// Line store holding the previous row's summed-area words, one port each way.
module sat_line_store #(
   parameter int DEPTH = sat_pkg::DEFAULT_MAX_WIDTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output sat_pkg::sat_rgb_sum_type rd_data,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  sat_pkg::sat_rgb_sum_type wr_data
);

   sat_pkg::sat_rgb_sum_type mem_ff [DEPTH];
   sat_pkg::sat_rgb_sum_type rd_data_ff;

   // Read data is registered and holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
